// ----- hw/rtl/rfc_pkg.sv -----
// Shared constants for the rainflow cycle counter.
// Result kind codes and default sizes; no dependencies.
package rfc_pkg;

  localparam int STACK_DEPTH_DEF  = 32;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_HALF = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

endpackage

// ----- hw/rtl/rainflow_cycle_counter.sv -----
// Rainflow cycle counter, residue-stack form.
// Uses rfc_pkg (kind codes, defaults) and rfc_stack_ram (residue storage).
//
// s_axis: one turning point per beat, tlast on the final extremum of a
//   sequence. m_axis: zero or more cycle results per input beat, tlast on
//   the last result caused by that input; a final input always yields at
//   least the end marker. Each result carries the exact range |p-q|, the
//   sum p+q of its two turning points and the sticky overflow flag.
// The stack lives in a RAM at a circular base offset; the top three entries
//   are mirrored in registers. A push is followed by the range check and
//   the drain of the pending result. Each full cycle reduction reloads the
//   mirrored entries from RAM through LOAD1, LOAD2 and, if needed, LOAD3; a
//   half-cycle drop needs no reload. The end-of-sequence flush reads each
//   residue entry through FRD and FCAP, then makes the marker in FEND and
//   drains it in FIN. One input is in work at a time; s_axis_tready is high
//   only when idle. Results pass through a one-deep holding stage and an
//   output register, so the flag for the last result is known before it is shown.
// Reset clears the stack fill, the overflow flag and all valid bits. When
//   m_axis_tready is low the sequencer stalls at a result that finds both result stages full, no loss.
module rainflow_cycle_counter #(
  parameter int STACK_DEPTH  = rfc_pkg::STACK_DEPTH_DEF,
  parameter int SAMPLE_WIDTH = rfc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  // s_axis_tdata: [SAMPLE_WIDTH-1:0] turning_value, rest zero
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  input  logic                                   s_axis_tlast,
  // m_axis_tdata: cycle_range (SAMPLE_WIDTH), level_sum (SAMPLE_WIDTH+1),
  //               overflow_seen (1), zero pad
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((2*SAMPLE_WIDTH+2+7)/8)*8-1:0]  m_axis_tdata,
  // m_axis_tuser: cycle_kind
  output logic [rfc_pkg::KIND_W-1:0]             m_axis_tuser,
  output logic                                   m_axis_tlast
);
  import rfc_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int FW  = $clog2(STACK_DEPTH + 1);
  localparam int ODW = ((2*SAMPLE_WIDTH+2+7)/8)*8;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CHECK = 4'd1;
  localparam logic [3:0] ST_LOAD1 = 4'd2;
  localparam logic [3:0] ST_LOAD2 = 4'd3;
  localparam logic [3:0] ST_LOAD3 = 4'd4;
  localparam logic [3:0] ST_FRD   = 4'd5;
  localparam logic [3:0] ST_FCAP  = 4'd6;
  localparam logic [3:0] ST_FEND  = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  // logical stack index -> RAM address, circular from base
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [FW-1:0] i);
    logic [AW:0] s;
    s = (AW+1)'(b) + (AW+1)'(i);
    if (s >= (AW+1)'(STACK_DEPTH)) begin
      s = s - (AW+1)'(STACK_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // control state
  logic [3:0]    state;
  logic [FW-1:0] fill;
  logic [AW-1:0] base;
  logic          ovf;
  logic          last_item;
  logic [FW-1:0] idx;

  // top-of-stack mirror: top = s[fill-1], sec = s[fill-2], thr = s[fill-3]
  logic signed [SW-1:0] top, sec, thr, prev;

  // pending result (held until the next one or the end of the item)
  logic                 pend_v;
  logic [KIND_W-1:0]    pend_kind;
  logic [SW-1:0]        pend_range;
  logic signed [SW:0]   pend_sum;
  logic                 pend_ovf;

  // output register
  logic                 out_v;
  logic [KIND_W-1:0]    out_kind;
  logic [SW-1:0]        out_range;
  logic signed [SW:0]   out_sum;
  logic                 out_ovf;
  logic                 out_last;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic signed [SW-1:0] rd_val;

  rfc_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (SW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_val = $signed(ram_rdata);

  logic signed [SW-1:0] in_val;
  assign in_val = $signed(s_axis_tdata[SW-1:0]);

  logic in_fire;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // newer range |top - sec|
  logic signed [SW:0] d_new, n_new;
  logic [SW-1:0]      r_new;
  assign d_new = {top[SW-1], top} - {sec[SW-1], sec};
  assign n_new = -d_new;
  assign r_new = d_new[SW] ? n_new[SW-1:0] : d_new[SW-1:0];

  // result operands
  logic                 em_go;
  logic [KIND_W-1:0]    em_kind;
  logic signed [SW-1:0] em_p, em_q;
  logic signed [SW:0]   d_em, n_em, em_sum;
  logic [SW-1:0]        em_range;
  logic                 reduce;

  always_comb begin
    em_kind = KIND_HALF;
    em_p    = '0;
    em_q    = '0;
    case (state)
      ST_CHECK: begin
        if (fill == FW'(3)) begin
          em_p = thr;
          em_q = sec;
        end else begin
          em_kind = KIND_FULL;
          em_p    = sec;
          em_q    = thr;
        end
      end
      ST_FCAP: begin
        em_p = prev;
        em_q = rd_val;
      end
      ST_FEND: begin
        em_kind = KIND_END;
      end
      default: begin
        em_kind = KIND_HALF;
      end
    endcase
  end

  assign d_em     = {em_p[SW-1], em_p} - {em_q[SW-1], em_q};
  assign n_em     = -d_em;
  assign em_range = d_em[SW] ? n_em[SW-1:0] : d_em[SW-1:0];
  assign em_sum   = {em_p[SW-1], em_p} + {em_q[SW-1], em_q};

  // older range no greater than newer range
  assign reduce = (state == ST_CHECK) && (fill >= FW'(3)) && (em_range <= r_new);

  always_comb begin
    case (state)
      ST_CHECK: em_go = reduce && (em_range != '0);
      ST_FCAP:  em_go = (idx != '0) && (em_range != '0);
      ST_FEND:  em_go = 1'b1;
      default:  em_go = 1'b0;
    endcase
  end

  logic out_free, room, advance, emit, drain;
  assign out_free = !out_v || m_axis_tready;
  assign room     = !pend_v || out_free;
  assign advance  = !em_go || room;
  assign emit     = em_go && room;
  assign drain    = (state == ST_FIN) && pend_v && out_free;

  // RAM addressing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys(base, fill);
    ram_wdata = in_val;
    if (in_fire && (fill < FW'(STACK_DEPTH))) begin
      ram_we = 1'b1;
    end else if (reduce && advance && (fill != FW'(3))) begin
      // s[t-2] <= s[t]
      ram_we    = 1'b1;
      ram_waddr = phys(base, fill - FW'(3));
      ram_wdata = top;
    end
  end

  always_comb begin
    case (state)
      ST_LOAD1: ram_raddr = phys(base, fill - FW'(2));
      ST_LOAD2: ram_raddr = phys(base, fill - FW'(3));
      default:  ram_raddr = phys(base, idx);
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      base      <= '0;
      ovf       <= 1'b0;
      last_item <= 1'b0;
      idx       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            last_item <= s_axis_tlast;
            if (fill < FW'(STACK_DEPTH)) begin
              fill <= fill + FW'(1);
              top  <= in_val;
              sec  <= top;
              thr  <= sec;
            end else begin
              ovf <= 1'b1;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (advance) begin
            if (reduce) begin
              if (fill == FW'(3)) begin
                // drop the oldest entry
                fill <= FW'(2);
                base <= (base == AW'(STACK_DEPTH - 1)) ? '0 : base + AW'(1);
              end else begin
                fill  <= fill - FW'(2);
                state <= ST_LOAD1;
              end
            end else if (last_item) begin
              idx   <= '0;
              state <= (fill >= FW'(2)) ? ST_FRD : ST_FEND;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_LOAD1: begin
          state <= ST_LOAD2;
        end
        ST_LOAD2: begin
          sec   <= rd_val;
          state <= (fill >= FW'(3)) ? ST_LOAD3 : ST_CHECK;
        end
        ST_LOAD3: begin
          thr   <= rd_val;
          state <= ST_CHECK;
        end
        ST_FRD: begin
          state <= ST_FCAP;
        end
        ST_FCAP: begin
          if (advance) begin
            prev <= rd_val;
            idx  <= idx + FW'(1);
            state <= ((idx + FW'(1)) < fill) ? ST_FRD : ST_FEND;
          end
        end
        ST_FEND: begin
          if (advance) begin
            fill  <= '0;
            ovf   <= 1'b0;
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!pend_v || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // pending stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      out_v  <= 1'b0;
    end else begin
      if ((emit || drain) && pend_v) begin
        out_v     <= 1'b1;
        out_kind  <= pend_kind;
        out_range <= pend_range;
        out_sum   <= pend_sum;
        out_ovf   <= pend_ovf;
        out_last  <= drain;
      end else if (out_v && m_axis_tready) begin
        out_v <= 1'b0;
      end
      if (emit) begin
        pend_v     <= 1'b1;
        pend_kind  <= em_kind;
        pend_range <= em_range;
        pend_sum   <= em_sum;
        pend_ovf   <= ovf;
      end else if (drain) begin
        pend_v <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = ODW'({out_ovf, out_sum, out_range});
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(STACK_DEPTH))
    else $error("stack fill beyond depth");

  a_base_bound: assert property (@(posedge clk) disable iff (rst)
    base < AW'(STACK_DEPTH - 1) || base == AW'(STACK_DEPTH - 1))
    else $error("base pointer out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("pending result left at idle");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FEND && room) |=> (fill == '0 && !ovf && pend_v && pend_kind == KIND_END))
    else $error("end marker did not close the sequence");

  a_reload_fill: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD2) |-> (fill >= FW'(2)))
    else $error("stack reload with too few entries");

endmodule

// ----- hw/rtl/rfc_stack_ram.sv -----
// Residue stack storage: one write port, one read port, registered read data.
// Uses no package items.
module rfc_stack_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
